// ===== src/osm_pkg.sv =====
package osm_pkg;

	typedef logic signed [31:0] word_t;
	typedef logic [1:0] stat_t;

	// operation codes of the cmd field
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_GET    = 1'b1;

	// result status codes
	localparam stat_t STAT_OK      = 2'd0;
	localparam stat_t STAT_RANGE   = 2'd1;
	localparam stat_t STAT_DROPPED = 2'd2;

	// values per first-level group of the readout tree
	localparam int GROUP = 16;

	// insert broadcast from the top level to every cell
	typedef struct packed {
		logic  ins_en;
		word_t ins_val;
	} cell_ctl_t;

endpackage

// ===== src/osm_cell.sv =====
module osm_cell #(
	parameter int IDX = 0,
	parameter int CW  = 9,
	parameter int RW  = 10
) (
	input  logic               clk,
	input  osm_pkg::cell_ctl_t ctl,
	input  logic [CW-1:0]      count,
	input  logic [RW-1:0]      rank,
	input  logic               prev_gt,
	input  osm_pkg::word_t     prev_val,
	output logic               gt,
	output osm_pkg::word_t     val,
	output osm_pkg::word_t     sel_val
);

	osm_pkg::word_t val_q;
	logic           occupied;
	logic           at_tail;

	// locate this cell against the fill level
	assign occupied = (CW'(IDX) < count);
	assign at_tail  = (CW'(IDX) == count);
	assign gt       = occupied && (val_q > ctl.ins_val);
	assign val      = val_q;

	// drive the held value only when this cell holds the requested rank
	assign sel_val = (rank == RW'(IDX + 1)) ? val_q : '0;

	// shift up when the left neighbor is greater, else take the new value at its slot
	always_ff @(posedge clk) begin
		if (ctl.ins_en) begin
			if (prev_gt) begin
				val_q <= prev_val;
			end else if (gt || at_tail) begin
				val_q <= ctl.ins_val;
			end
		end
	end

endmodule

// ===== src/order_statistic_multiset.sv =====
// Sorted multiset of signed 32-bit values held in a row of CAPACITY cells.
// An insert (cmd 0) updates all cells together: every cell compares its value with
// the new one in parallel, greater values move one cell up and the new value
// drops into the gap, so duplicates are kept. An insert into a full store is
// dropped and sets a sticky flag that turns later ok results into status 2.
// A get (cmd 1) steps an internal rank counter and returns the value of that
// rank, counting from the smallest; status 1 with value 0 when the rank is
// past the count. Items may arrive every cycle while the input is not stalled.
// A get result is registered in order: the rank counter steps, the cells select
// the ranked value and OR it within each group into the group register, and the
// group results combine into the output register.
// Inserts give no result. While a result is stalled at the output the whole
// block holds and stalls its input.
module order_statistic_multiset #(
	parameter int CAPACITY = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  logic                  cmd,
	input  logic signed [31:0]    value,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output logic signed [31:0]    ranked_value,
	output logic [1:0]            status
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int RW = $clog2(CAPACITY + 2);
	localparam int NG = (CAPACITY + osm_pkg::GROUP - 1) / osm_pkg::GROUP;
	localparam int NP = NG * osm_pkg::GROUP;

	logic               adv;
	logic               acc;
	logic               is_get;
	logic               full;
	logic               ins_go;
	osm_pkg::cell_ctl_t ctl;

	logic [CW-1:0]      count_q;
	logic [RW-1:0]      query_rank_q;
	logic               dropped_q;

	logic               rd_vld_q;
	logic               rd_err;

	logic               gt_c  [CAPACITY];
	osm_pkg::word_t     val_c [CAPACITY];
	osm_pkg::word_t     sel_pad [NP];
	osm_pkg::word_t     grp_or [NG];

	osm_pkg::word_t     grp_s1 [NG];
	logic               vld_s1;
	logic               err_s1;
	logic               drop_s1;
	osm_pkg::word_t     tree_or;

	logic               out_vld_q;
	osm_pkg::word_t     out_val_q;
	osm_pkg::stat_t     out_stat_q;

	// freeze everything while a result waits on a stalled output
	assign adv       = !out_vld_q || !rsp_stall;
	assign req_stall = !adv;
	assign acc       = req_valid && adv;
	assign is_get    = (cmd == osm_pkg::CMD_GET);
	assign full      = (count_q == CW'(CAPACITY));
	assign ins_go    = acc && !is_get && !full;

	assign ctl.ins_en  = ins_go;
	assign ctl.ins_val = value;

	// row of cells, each fed by its left neighbor
	for (genvar i = 0; i < NP; i++) begin : g_cell
		if (i < CAPACITY) begin : g_live
			osm_cell #(
				.IDX(i),
				.CW (CW),
				.RW (RW)
			) u_cell (
				.clk     (clk),
				.ctl     (ctl),
				.count   (count_q),
				.rank    (query_rank_q),
				.prev_gt ((i == 0) ? 1'b0 : gt_c[(i == 0) ? 0 : i - 1]),
				.prev_val(val_c[(i == 0) ? 0 : i - 1]),
				.gt      (gt_c[i]),
				.val     (val_c[i]),
				.sel_val (sel_pad[i])
			);
		end else begin : g_pad
			assign sel_pad[i] = '0;
		end
	end

	// first tree level: OR the selected values within each group
	for (genvar g = 0; g < NG; g++) begin : g_grp
		always_comb begin
			grp_or[g] = '0;
			for (int j = 0; j < osm_pkg::GROUP; j++) begin
				grp_or[g] = grp_or[g] | sel_pad[g * osm_pkg::GROUP + j];
			end
		end
	end

	// second tree level: OR the group results
	always_comb begin
		tree_or = '0;
		for (int g = 0; g < NG; g++) begin
			tree_or = tree_or | grp_s1[g];
		end
	end

	assign rd_err = (query_rank_q > RW'(count_q));

	// fill level, rank counter and drop flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			query_rank_q <= '0;
			dropped_q    <= 1'b0;
		end else if (acc) begin
			if (!is_get) begin
				if (full) begin
					dropped_q <= 1'b1;
				end else begin
					count_q <= count_q + 1'b1;
				end
			end else if (query_rank_q != RW'(CAPACITY + 1)) begin
				query_rank_q <= query_rank_q + 1'b1;
			end
		end
	end

	// advance the readout pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_q  <= 1'b0;
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			rd_vld_q  <= acc && is_get;
			vld_s1    <= rd_vld_q;
			out_vld_q <= vld_s1;
		end
	end

	// capture group ORs and status during the read cycle
	always_ff @(posedge clk) begin
		if (adv) begin
			grp_s1  <= grp_or;
			err_s1  <= rd_err;
			drop_s1 <= dropped_q;
		end
	end

	// form the result
	always_ff @(posedge clk) begin
		if (adv) begin
			if (err_s1) begin
				out_val_q  <= '0;
				out_stat_q <= osm_pkg::STAT_RANGE;
			end else begin
				out_val_q  <= tree_or;
				out_stat_q <= drop_s1 ? osm_pkg::STAT_DROPPED : osm_pkg::STAT_OK;
			end
		end
	end

	assign rsp_valid    = out_vld_q;
	assign ranked_value = out_val_q;
	assign status       = out_stat_q;

	// fill level never passes the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("fill level above capacity");

	// an error result carries a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status == osm_pkg::STAT_RANGE) |-> (ranked_value == '0))
		else $error("range error with nonzero value");

	// an insert into a non-full store grows the fill level by one
	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		ins_go |=> (count_q == $past(count_q) + 1'b1))
		else $error("insert did not grow fill level");

	// a dropped insert leaves the flag set for good
	a_drop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		dropped_q |=> dropped_q)
		else $error("drop flag cleared");

endmodule
